/* src/pffs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// pffs_pkg: shared constants, types and the arctangent table for the firing solution core.
// No dependencies.
package pffs_pkg;

    localparam int DISTANCE_BITS = 12;
    localparam int FRACTION_BITS = 8;
    localparam int CORDIC_STEPS  = 16;

    localparam int DIST_IN_W  = 12;
    localparam int AZIM_IN_W  = 9;
    localparam int RANGE_W    = 14;
    localparam int BEARING_W  = 9;

    localparam int TABLE_LEN  = 24;
    localparam int ANG_FRAC   = 22;
    localparam int STEPS_USED = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int STEP_W     = $clog2(TABLE_LEN);

    localparam int COORD_W  = DISTANCE_BITS + FRACTION_BITS + 1;
    localparam int DIFF_W   = COORD_W + 3;
    localparam int MB_W     = 32;
    localparam int PROD_W   = DIFF_W + MB_W;
    localparam int VEC_W    = DIFF_W + 19;
    localparam int Z_W      = 33;
    localparam int RND_SH   = 30 - FRACTION_BITS;
    localparam int RANGE_SH = 16 + FRACTION_BITS;

    localparam int UNIT_Q30  = 652032874;
    localparam int GAIN_Q16  = 39797;
    localparam int RANGE_MAX = 16383;
    localparam int HALF_TURN = 180;
    localparam int FULL_TURN = 360;
    localparam int QTR_TURN  = 90;

    localparam logic [1:0] STAGE_GUN    = 2'd0;
    localparam logic [1:0] STAGE_TARGET = 2'd1;
    localparam logic [1:0] STAGE_IMPACT = 2'd2;
    localparam logic [1:0] STAGE_CLEAR  = 2'd3;

    typedef struct packed {
        logic                load;
        logic                rot_init;
        logic                step;
        logic                vector;
        logic [STEP_W-1:0]   step_idx;
        logic                mul_x;
        logic                mul_y;
        logic                put_py;
        logic                apply;
        logic                gain_x;
        logic                gain_y;
        logic                vec_init;
        logic                finish;
        logic                emit;
        logic [1:0]          stage;
    } t_cmd;

    typedef struct packed {
        logic accept;
        logic out_free;
    } t_sts;

    function automatic logic [31:0] atan_deg(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd188743680;
            5'd1:  v = 32'd111421900;
            5'd2:  v = 32'd58872272;
            5'd3:  v = 32'd29884485;
            5'd4:  v = 32'd15000234;
            5'd5:  v = 32'd7507429;
            5'd6:  v = 32'd3754631;
            5'd7:  v = 32'd1877430;
            5'd8:  v = 32'd938729;
            5'd9:  v = 32'd469366;
            5'd10: v = 32'd234683;
            5'd11: v = 32'd117342;
            5'd12: v = 32'd58671;
            5'd13: v = 32'd29335;
            5'd14: v = 32'd14668;
            5'd15: v = 32'd7334;
            5'd16: v = 32'd3667;
            5'd17: v = 32'd1833;
            5'd18: v = 32'd917;
            5'd19: v = 32'd458;
            5'd20: v = 32'd229;
            5'd21: v = 32'd115;
            5'd22: v = 32'd57;
            5'd23: v = 32'd29;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/pffs_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// pffs_in_if / pffs_out_if: valid-ready channels for fixes and solutions.
// Depends on pffs_pkg.
interface pffs_in_if;
    logic                              valid;
    logic                              ready;
    logic [pffs_pkg::DIST_IN_W-1:0]    fix_distance;
    logic [pffs_pkg::AZIM_IN_W-1:0]    fix_azimuth;
    modport source (output valid, output fix_distance, output fix_azimuth, input ready);
    modport sink   (input valid, input fix_distance, input fix_azimuth, output ready);
endinterface

interface pffs_out_if;
    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              stage_taken;
    logic                                    solution_valid;
    logic [pffs_pkg::RANGE_W-1:0]            solution_range;
    logic signed [pffs_pkg::BEARING_W-1:0]   solution_bearing;
    modport source (output valid, output stage_taken, output solution_valid,
                    output solution_range, output solution_bearing, input ready);
    modport sink   (input valid, input stage_taken, input solution_valid,
                    input solution_range, input solution_bearing, output ready);
endinterface
`default_nettype wire

/* src/pffs_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// pffs_ctrl: sequencer for stage handling, CORDIC step counting and result handoff.
// Depends on pffs_pkg.
module pffs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pffs_pkg::t_sts i_sts,
    output pffs_pkg::t_cmd     o_cmd,
    output logic               o_ready
);
    import pffs_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RINIT = 13'b0000000000010,
        S_ROT   = 13'b0000000000100,
        S_MX    = 13'b0000000001000,
        S_MY    = 13'b0000000010000,
        S_PY    = 13'b0000000100000,
        S_APPLY = 13'b0000001000000,
        S_GX    = 13'b0000010000000,
        S_GY    = 13'b0000100000000,
        S_VINIT = 13'b0001000000000,
        S_VEC   = 13'b0010000000000,
        S_FIN   = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS_USED - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [1:0]        r_stage, n_stage;
    logic              w_solve;

    assign w_solve = (r_stage == STAGE_TARGET) || (r_stage == STAGE_IMPACT);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_stage = r_stage;
        o_cmd   = '0;
        o_cmd.stage    = r_stage;
        o_cmd.step_idx = r_step;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_sts.accept) begin
                    o_cmd.load = 1'b1;
                    n_state = S_RINIT;
                end
            end
            S_RINIT: begin
                o_cmd.rot_init = 1'b1;
                n_step  = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                o_cmd.step = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_MX;
                end
            end
            S_MX: begin
                o_cmd.mul_x = 1'b1;
                n_state = S_MY;
            end
            S_MY: begin
                o_cmd.mul_y = 1'b1;
                n_state = S_PY;
            end
            S_PY: begin
                o_cmd.put_py = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = w_solve ? S_GX : S_FIN;
            end
            S_GX: begin
                o_cmd.gain_x = 1'b1;
                n_state = S_GY;
            end
            S_GY: begin
                o_cmd.gain_y = 1'b1;
                n_state = S_VINIT;
            end
            S_VINIT: begin
                o_cmd.vec_init = 1'b1;
                n_step  = '0;
                n_state = S_VEC;
            end
            S_VEC: begin
                o_cmd.step   = 1'b1;
                o_cmd.vector = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_stage = r_stage + 2'd1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_stage <= STAGE_GUN;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_stage <= n_stage;
        end
    end

endmodule
`default_nettype wire

/* src/pffs_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// pffs_dp: shared CORDIC unit, shared multiplier and stored gun/target positions.
// Depends on pffs_pkg.
module pffs_dp (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire pffs_pkg::t_cmd                        i_cmd,
    input  wire logic [pffs_pkg::DIST_IN_W-1:0]        i_fix_distance,
    input  wire logic [pffs_pkg::AZIM_IN_W-1:0]        i_fix_azimuth,
    output logic [pffs_pkg::RANGE_W-1:0]               o_range,
    output logic signed [pffs_pkg::BEARING_W-1:0]      o_bearing
);
    import pffs_pkg::*;

    localparam int DMAX = (1 << DISTANCE_BITS) - 1;
    localparam logic signed [COORD_W-1:0] C_LIM = COORD_W'((1 << (COORD_W - 1)) - 1);

    logic [DISTANCE_BITS-1:0]     r_d;
    logic                         r_neg;
    logic signed [VEC_W-1:0]      r_x, r_y;
    logic signed [Z_W-1:0]        r_z;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [COORD_W-1:0]    r_px, r_py;
    logic signed [COORD_W-1:0]    r_gx, r_gy, r_tx, r_ty;
    logic signed [DIFF_W-1:0]     r_dx, r_dy;

    logic [31:0]                  w_dext;
    logic signed [10:0]           w_am, w_af;
    logic                         w_fneg;
    logic signed [DIFF_W-1:0]     w_ma;
    logic signed [MB_W-1:0]       w_mb, w_xlo, w_ylo;
    logic signed [VEC_W-1:0]      w_xs, w_ys;
    logic signed [Z_W-1:0]        w_at;
    logic                         w_ccw;
    logic signed [COORD_W-1:0]    w_pr;
    logic signed [PROD_W-1:0]     w_rnd;
    logic signed [VEC_W-1:0]      w_rq;
    logic signed [Z_W-1:0]        w_zmag, w_zq;
    logic signed [Z_W-1:0]        w_deg;
    logic                         w_zero, w_solve;

    always_comb begin
        w_dext = 32'(i_fix_distance);
        w_am = (11'(i_fix_azimuth) >= 11'(FULL_TURN)) ?
               11'(i_fix_azimuth) - 11'(FULL_TURN) : 11'(i_fix_azimuth);
        if (w_am > 11'sd180) begin
            w_am = w_am - 11'(FULL_TURN);
        end
        w_fneg = 1'b0;
        w_af   = w_am;
        if (w_am > 11'(QTR_TURN)) begin
            w_af = w_am - 11'(HALF_TURN);
            w_fneg = 1'b1;
        end else if (w_am < -11'sd90) begin
            w_af = w_am + 11'(HALF_TURN);
            w_fneg = 1'b1;
        end
    end

    always_comb begin
        w_xlo = r_x[MB_W-1:0];
        w_ylo = r_y[MB_W-1:0];
        w_ma  = DIFF_W'($signed({1'b0, r_d}));
        w_mb  = r_neg ? -w_xlo : w_xlo;
        if (i_cmd.mul_y) begin
            w_mb = r_neg ? -w_ylo : w_ylo;
        end else if (i_cmd.gain_x) begin
            w_ma = r_dx;
            w_mb = MB_W'(GAIN_Q16);
        end else if (i_cmd.gain_y) begin
            w_ma = r_dy;
            w_mb = MB_W'(GAIN_Q16);
        end
    end

    always_comb begin
        w_xs  = r_x >>> i_cmd.step_idx;
        w_ys  = r_y >>> i_cmd.step_idx;
        w_at  = Z_W'(atan_deg(i_cmd.step_idx));
        w_ccw = i_cmd.vector ? r_y[VEC_W-1] : !r_z[Z_W-1];
    end

    always_comb begin
        w_rnd = (r_prod + (PROD_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
        if (w_rnd > PROD_W'(C_LIM)) begin
            w_pr = C_LIM;
        end else if (w_rnd < -PROD_W'(C_LIM)) begin
            w_pr = -C_LIM;
        end else begin
            w_pr = w_rnd[COORD_W-1:0];
        end
    end

    always_comb begin
        w_rq   = r_x >>> RANGE_SH;
        w_zmag = r_z[Z_W-1] ? -r_z : r_z;
        w_zq   = w_zmag >>> ANG_FRAC;
        if (w_zq > Z_W'(HALF_TURN)) begin
            w_zq = Z_W'(HALF_TURN);
        end
        w_deg   = r_z[Z_W-1] ? -w_zq : w_zq;
        w_zero  = (r_dx == '0) && (r_dy == '0);
        w_solve = (i_cmd.stage == STAGE_TARGET) || (i_cmd.stage == STAGE_IMPACT);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d <= (w_dext > 32'(DMAX)) ? DISTANCE_BITS'(DMAX) : DISTANCE_BITS'(w_dext);
            r_neg <= w_fneg;
            r_z <= Z_W'(w_af) <<< ANG_FRAC;
        end
        if (i_cmd.rot_init) begin
            r_x <= VEC_W'(UNIT_Q30);
            r_y <= '0;
        end
        if (i_cmd.step) begin
            if (w_ccw) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
        if (i_cmd.mul_x || i_cmd.mul_y || i_cmd.gain_x || i_cmd.gain_y) begin
            r_prod <= PROD_W'(w_ma) * PROD_W'(w_mb);
        end
        if (i_cmd.mul_y) begin
            r_px <= w_pr;
        end
        if (i_cmd.put_py) begin
            r_py <= w_pr;
        end
        if (i_cmd.gain_y) begin
            r_x <= VEC_W'(r_prod);
        end
        if (i_cmd.vec_init) begin
            if (r_dx[DIFF_W-1]) begin
                r_x <= -r_x;
                r_y <= -VEC_W'(r_prod);
                r_z <= r_dy[DIFF_W-1] ? -(Z_W'(HALF_TURN) <<< ANG_FRAC)
                                      : (Z_W'(HALF_TURN) <<< ANG_FRAC);
            end else begin
                r_y <= VEC_W'(r_prod);
                r_z <= '0;
            end
        end
        if (!i_rst_n) begin
            r_gx <= '0;
            r_gy <= '0;
            r_tx <= '0;
            r_ty <= '0;
        end else if (i_cmd.apply) begin
            r_dx <= '0;
            r_dy <= '0;
            case (i_cmd.stage)
                STAGE_GUN: begin
                    r_gx <= r_px;
                    r_gy <= r_py;
                end
                STAGE_TARGET: begin
                    r_tx <= r_px;
                    r_ty <= r_py;
                    r_dx <= DIFF_W'(r_px) - DIFF_W'(r_gx);
                    r_dy <= DIFF_W'(r_py) - DIFF_W'(r_gy);
                end
                STAGE_IMPACT: begin
                    r_dx <= (DIFF_W'(r_tx) <<< 1) - DIFF_W'(r_px) - DIFF_W'(r_gx);
                    r_dy <= (DIFF_W'(r_ty) <<< 1) - DIFF_W'(r_py) - DIFF_W'(r_gy);
                end
                default: begin
                    r_gx <= '0;
                    r_gy <= '0;
                    r_tx <= '0;
                    r_ty <= '0;
                end
            endcase
        end
        if (i_cmd.finish) begin
            if (!w_solve || w_zero) begin
                o_range   <= '0;
                o_bearing <= '0;
            end else begin
                if (w_rq < 0) begin
                    o_range <= '0;
                end else if (w_rq > VEC_W'(RANGE_MAX)) begin
                    o_range <= RANGE_W'(RANGE_MAX);
                end else begin
                    o_range <= w_rq[RANGE_W-1:0];
                end
                o_bearing <= w_deg[BEARING_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

/* src/polar_fix_firing_solution_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Firing solution core: one result item per fix. Target and impact fixes pass through the
// shared CORDIC unit twice, CORDIC_STEPS iterations each, plus multiply, store and result
// handoff steps. Gun and clear fixes skip the vectoring pass. The core returns to idle
// before the next fix is taken, and a full result register adds its wait. Stage cycles
// gun, target, impact, clear. A new item is taken while the last result waits.
// Depends on pffs_pkg, pffs_if, pffs_ctrl, pffs_dp.
module polar_fix_firing_solution_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pffs_in_if.sink      i_in,
    pffs_out_if.source   o_out
);
    import pffs_pkg::*;

    t_cmd                        w_cmd;
    t_sts                        w_sts;
    logic                        w_ready;
    logic [RANGE_W-1:0]          w_range;
    logic signed [BEARING_W-1:0] w_bearing;
    logic                        r_ovalid;
    logic [1:0]                  r_stage;
    logic                        r_svalid;
    logic [RANGE_W-1:0]          r_range;
    logic signed [BEARING_W-1:0] r_bearing;

    assign i_in.ready       = w_ready;
    assign w_sts.accept     = i_in.valid && w_ready;
    assign w_sts.out_free   = !r_ovalid || o_out.ready;

    pffs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_ready (w_ready)
    );

    pffs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_fix_distance (i_in.fix_distance),
        .i_fix_azimuth  (i_in.fix_azimuth),
        .o_range        (w_range),
        .o_bearing      (w_bearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (w_cmd.emit) begin
            r_stage   <= w_cmd.stage;
            r_svalid  <= (w_cmd.stage == STAGE_TARGET) || (w_cmd.stage == STAGE_IMPACT);
            r_range   <= w_range;
            r_bearing <= w_bearing;
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.stage_taken      = r_stage;
    assign o_out.solution_valid   = r_svalid;
    assign o_out.solution_range   = r_range;
    assign o_out.solution_bearing = r_bearing;

    a_valid_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.solution_valid ==
            ((o_out.stage_taken == STAGE_TARGET) || (o_out.stage_taken == STAGE_IMPACT))))
        else $error("solution flag does not match stage");

    a_no_sol_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.solution_valid) |->
            (o_out.solution_range == '0) && (o_out.solution_bearing == '0))
        else $error("nonzero solution in a stage without one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item taken while busy");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!r_ovalid || o_out.ready))
        else $error("result overwritten before taken");

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// testbench: regression for polar_fix_firing_solution_core, directed fixes then random
// stage cycles checked against a bit-accurate CORDIC predictor. Depends on pffs_pkg, pffs_if.
module testbench;
    import pffs_pkg::*;

    typedef struct packed {
        logic [1:0]  stage;
        logic        valid;
        logic [13:0] range;
        logic [8:0]  bearing;
    } t_sol;

    typedef struct {
        logic [11:0] fdist;
        logic [8:0]  azim;
        bit          typed;
        t_sol        sol;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    pffs_in_if  fix_ch ();
    pffs_out_if sol_ch ();

    polar_fix_firing_solution_core u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (fix_ch),
        .o_out  (sol_ch)
    );

    longint atan_q22 [24] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29};

    logic [1:0] lay_stage;
    longint     gun_x, gun_y, tgt_x, tgt_y;
    t_sol       sol_q[$];
    int         n_errors;
    int         n_fixes;
    int         n_sols;
    bit         feed_done;
    bit         hold_off;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_xy(longint v);
        longint lim;
        lim = (longint'(1) <<< (COORD_W - 1)) - 1;
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic void fix_to_xy(input logic [11:0] fdist, input logic [8:0] azim,
                                      output longint px, output longint py);
        longint d, a, x, y, z, nx;
        bit flip;
        d = fdist;
        a = azim % 360;
        flip = 0;
        x = UNIT_Q30;
        y = 0;
        if (a > 180) a -= 360;
        if (a > 90) begin
            a -= 180;
            flip = 1;
        end else if (a < -90) begin
            a += 180;
            flip = 1;
        end
        z = a <<< ANG_FRAC;
        for (int i = 0; i < STEPS_USED; i++) begin
            if (z >= 0) begin
                nx = x - floor_sh(y, i);
                y = y + floor_sh(x, i);
                z -= atan_q22[i];
            end else begin
                nx = x + floor_sh(y, i);
                y = y - floor_sh(x, i);
                z += atan_q22[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        px = clamp_xy(floor_sh(d * x + (longint'(1) <<< (RND_SH - 1)), RND_SH));
        py = clamp_xy(floor_sh(d * y + (longint'(1) <<< (RND_SH - 1)), RND_SH));
    endfunction

    function automatic void aim(longint dx, longint dy, ref t_sol s);
        longint x, y, z, nx, r, deg;
        s.valid = 1;
        if (dx == 0 && dy == 0) begin
            s.range = 0;
            s.bearing = 0;
            return;
        end
        x = dx * GAIN_Q16;
        y = dy * GAIN_Q16;
        z = 0;
        if (x < 0) begin
            z = (dy >= 0 ? 180 : -180) * (longint'(1) <<< ANG_FRAC);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS_USED; i++) begin
            if (y >= 0) begin
                nx = x + floor_sh(y, i);
                y = y - floor_sh(x, i);
                z += atan_q22[i];
            end else begin
                nx = x - floor_sh(y, i);
                y = y + floor_sh(x, i);
                z -= atan_q22[i];
            end
            x = nx;
        end
        r = floor_sh(x, RANGE_SH);
        if (r < 0) r = 0;
        if (r > RANGE_MAX) r = RANGE_MAX;
        deg = z >= 0 ? (z >>> ANG_FRAC) : -((-z) >>> ANG_FRAC);
        if (deg > 180) deg = 180;
        if (deg < -180) deg = -180;
        s.range = r[13:0];
        s.bearing = deg[8:0];
    endfunction

    function automatic t_sol lay_gun(logic [11:0] fdist, logic [8:0] azim);
        t_sol s;
        longint px, py;
        s = '0;
        s.stage = lay_stage;
        case (lay_stage)
            STAGE_GUN: fix_to_xy(fdist, azim, gun_x, gun_y);
            STAGE_TARGET: begin
                fix_to_xy(fdist, azim, tgt_x, tgt_y);
                aim(tgt_x - gun_x, tgt_y - gun_y, s);
            end
            STAGE_IMPACT: begin
                fix_to_xy(fdist, azim, px, py);
                aim(2 * tgt_x - px - gun_x, 2 * tgt_y - py - gun_y, s);
            end
            default: begin
                gun_x = 0;
                gun_y = 0;
                tgt_x = 0;
                tgt_y = 0;
            end
        endcase
        lay_stage = lay_stage + 2'd1;
        return s;
    endfunction

    task automatic send_fix(input logic [11:0] fdist, input logic [8:0] azim);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            fix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        fix_ch.valid <= 1'b1;
        fix_ch.fix_distance <= fdist;
        fix_ch.fix_azimuth <= azim;
        @(posedge i_clk);
        while (!fix_ch.ready) @(posedge i_clk);
        n_fixes++;
    endtask

    task automatic put_fix(input logic [11:0] fdist, input logic [8:0] azim,
                           input bit typed, input t_sol want);
        t_sol s;
        s = lay_gun(fdist, azim);
        if (typed && s != want) begin
            $error("table row: predictor %h, typed %h", s, want);
            n_errors++;
        end
        sol_q.push_back(s);
        send_fix(fdist, azim);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("polar_fix_firing_solution_core regression: fail");
        $finish;
    end

    // receiver with random stalls
    initial begin
        int gap;
        sol_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                sol_ch.ready <= 1'b0;
            end else begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
                repeat (gap) @(posedge i_clk);
                sol_ch.ready <= 1'b1;
                @(posedge i_clk);
                while (!sol_ch.valid && !hold_off) @(posedge i_clk);
                sol_ch.ready <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_sol want;
        if (i_rst_n && sol_ch.valid && sol_ch.ready) begin
            n_sols++;
            if (sol_q.size() == 0) begin
                $error("solution with none expected");
                n_errors++;
            end else begin
                want = sol_q.pop_front();
                if (sol_ch.stage_taken !== want.stage) begin
                    $error("stage_taken exp %0d got %0d", want.stage, sol_ch.stage_taken);
                    n_errors++;
                end
                if (sol_ch.solution_valid !== want.valid) begin
                    $error("solution_valid exp %0d got %0d", want.valid,
                           sol_ch.solution_valid);
                    n_errors++;
                end
                if (sol_ch.solution_range !== want.range) begin
                    $error("solution_range exp %0d got %0d", want.range,
                           sol_ch.solution_range);
                    n_errors++;
                end
                if (sol_ch.solution_bearing !== want.bearing) begin
                    $error("solution_bearing exp %0d got %0d", $signed(want.bearing),
                           sol_ch.solution_bearing);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        int wait_n;
        logic [11:0] d;
        logic [8:0] a;
        lay_stage = STAGE_GUN;
        gun_x = 0; gun_y = 0; tgt_x = 0; tgt_y = 0;
        n_errors = 0; n_fixes = 0; n_sols = 0;
        feed_done = 0;
        hold_off = 0;
        i_rst_n = 1'b0;
        fix_ch.valid = 1'b0;
        fix_ch.fix_distance = '0;
        fix_ch.fix_azimuth = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // gun, target same spot, impact same spot, clear
        rows.push_back('{12'd0, 9'd0, 1, '{STAGE_GUN, 1'b0, 14'd0, 9'd0}});
        rows.push_back('{12'd0, 9'd0, 1, '{STAGE_TARGET, 1'b1, 14'd0, 9'd0}});
        rows.push_back('{12'd0, 9'd0, 1, '{STAGE_IMPACT, 1'b1, 14'd0, 9'd0}});
        rows.push_back('{12'd4095, 9'd511, 1, '{STAGE_CLEAR, 1'b0, 14'd0, 9'd0}});
        rows.push_back('{12'd4095, 9'd0, 0, '0});
        rows.push_back('{12'd4095, 9'd180, 0, '0});
        rows.push_back('{12'd4095, 9'd0, 0, '0});
        rows.push_back('{12'd1, 9'd1, 0, '0});
        rows.push_back('{12'd100, 9'd90, 0, '0});
        rows.push_back('{12'd100, 9'd270, 0, '0});
        rows.push_back('{12'd4095, 9'd359, 0, '0});
        rows.push_back('{12'd2, 9'd360, 0, '0});
        rows.push_back('{12'd4095, 9'd91, 0, '0});
        rows.push_back('{12'd4095, 9'd269, 0, '0});
        rows.push_back('{12'd4095, 9'd89, 0, '0});
        rows.push_back('{12'd3000, 9'd450, 0, '0});
        rows.push_back('{12'd1000, 9'd179, 0, '0});
        rows.push_back('{12'd1000, 9'd181, 0, '0});
        rows.push_back('{12'd0, 9'd0, 0, '0});
        rows.push_back('{12'd2048, 9'd256, 0, '0});
        foreach (rows[i]) put_fix(rows[i].fdist, rows[i].azim, rows[i].typed, rows[i].sol);

        fork
            begin
                wait (n_fixes >= 120);
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
        join_none

        for (int k = 0; k < 1100; k++) begin
            case ($urandom_range(0, 9))
                0: d = 12'd4095;
                1: d = 12'($urandom_range(0, 15));
                default: d = 12'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 9))
                0: a = 9'($urandom_range(360, 511));
                1: a = 9'(90 * $urandom_range(0, 3));
                default: a = 9'($urandom_range(0, 359));
            endcase
            put_fix(d, a, 0, '0);
        end
        fix_ch.valid <= 1'b0;
        feed_done = 1;

        wait_n = 0;
        while (sol_q.size() != 0 && wait_n < 20000) begin
            @(posedge i_clk);
            wait_n++;
        end
        repeat (100) @(posedge i_clk);
        if (sol_q.size() != 0) begin
            $error("%0d solutions never arrived", sol_q.size());
            n_errors++;
        end
        $display("Covered %0d fixes over all four stages, %0d results checked,",
                 n_fixes, n_sols);
        $display("including saturated distances, wrapped azimuths and a long output stall.");
        if (n_errors == 0)
            $display("polar_fix_firing_solution_core regression: pass");
        else
            $display("polar_fix_firing_solution_core regression: fail");
        $finish;
    end
endmodule
